// ===== rtl/core/fpfa_pkg.sv =====
// Package for the FIFO page-frame allocator.
// Holds sizes, request and status codes and the result record.
// No dependencies.
package fpfa_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int MAX_PROCS  = 4;
  localparam int MAX_PAGES  = 64;

  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int FCNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int SLOT_W  = $clog2(MAX_PROCS);
  localparam int PAGE_W  = $clog2(MAX_PAGES);
  localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
  localparam int MAP_W   = FRAME_W + 1;
  localparam int MAPA_W  = SLOT_W + PAGE_W;

  localparam logic [1:0] FN_CREATE = 2'd0;
  localparam logic [1:0] FN_ACCESS = 2'd1;
  localparam logic [1:0] FN_TERM   = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_FREE     = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_INACTIVE = 3'd4;
  localparam logic [2:0] ST_CREATED  = 3'd5;
  localparam logic [2:0] ST_TERM     = 3'd6;
  localparam logic [2:0] ST_REFUSED  = 3'd7;

  typedef struct packed {
    logic [2:0]         status;
    logic [FRAME_W-1:0] frame;
    logic               ev_valid;
    logic [SLOT_W-1:0]  ev_slot;
    logic [PAGE_W-1:0]  ev_page;
    logic [FCNT_W-1:0]  freed;
  } res_t;

endpackage

// ===== rtl/core/fpfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/fifo_page_frame_allocator.sv =====
// FIFO page-frame allocator: page tables in one RAM, FIFO ring in another.
// One request at a time: in_ready_o is high only in the idle state, so a new
// request is taken only after the previous result has moved to the output register.
// The page-table clear on create and terminate writes one entry per cycle;
// terminate also walks the FIFO ring and scans every frame before the clear.
// Reset: asynchronous, active low; frames free, slots inactive, FIFO empty.
module fifo_page_frame_allocator
  import fpfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [1:0]          process_slot_i,
  input  logic [5:0]          page_number_i,
  input  logic [6:0]          page_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [3:0]          frame_o,
  output logic                evicted_valid_o,
  output logic [1:0]          evicted_slot_o,
  output logic [5:0]          evicted_page_o,
  output logic [4:0]          freed_count_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [4:0]          cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_MAP   = 4'd4;
  localparam logic [3:0] S_TRD   = 4'd5;
  localparam logic [3:0] S_TCHK  = 4'd6;
  localparam logic [3:0] S_TFREE = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [4:0]          cfg_q;
  logic [1:0]          func_q, func_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [PAGE_W-1:0]   page_q, page_d;
  logic [FRAME_W-1:0]  head_q, head_d;
  logic [FCNT_W-1:0]   count_q, count_d;
  logic [FCNT_W-1:0]   k_q, k_d, nk_q, nk_d;
  logic [PAGE_W-1:0]   idx_q, idx_d;
  logic [FRAME_W-1:0]  victim_q, victim_d;
  res_t                res_q, res_d, out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [NUM_FRAMES-1:0] used_q, used_d;
  logic [SLOT_W-1:0]     owner_q [NUM_FRAMES];
  logic [SLOT_W-1:0]     owner_d [NUM_FRAMES];
  logic [PAGE_W-1:0]     fpage_q [NUM_FRAMES];
  logic [PAGE_W-1:0]     fpage_d [NUM_FRAMES];
  logic [MAX_PROCS-1:0]  active_q, active_d;
  logic [PCNT_W-1:0]     pages_q [MAX_PROCS];
  logic [PCNT_W-1:0]     pages_d [MAX_PROCS];

  logic              pm_we;
  logic [MAPA_W-1:0] pm_waddr, pm_raddr;
  logic [MAP_W-1:0]  pm_wdata, pm_rdata;
  logic              ff_we;
  logic [FRAME_W-1:0] ff_waddr, ff_raddr, ff_wdata, ff_rdata;

  logic [FCNT_W-1:0]  cap;
  logic [FRAME_W-1:0] free_idx;
  logic [FRAME_W-1:0] vic;
  logic [FRAME_W-1:0] tf;

  fpfa_ram #(.WIDTH(MAP_W), .DEPTH(MAX_PROCS * MAX_PAGES)) u_page_map (
    .clk_i, .we_i(pm_we), .waddr_i(pm_waddr), .wdata_i(pm_wdata),
    .raddr_i(pm_raddr), .rdata_o(pm_rdata)
  );

  fpfa_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_fifo (
    .clk_i, .we_i(ff_we), .waddr_i(ff_waddr), .wdata_i(ff_wdata),
    .raddr_i(ff_raddr), .rdata_o(ff_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  always_comb begin
    if (cfg_q == '0) begin
      cap = FCNT_W'(1);
    end else if (FCNT_W'(cfg_q) > FCNT_W'(NUM_FRAMES)) begin
      cap = FCNT_W'(NUM_FRAMES);
    end else begin
      cap = FCNT_W'(cfg_q);
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (FCNT_W'(i) < cap && !used_q[i]) begin
        free_idx = FRAME_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    slot_d      = slot_q;
    page_d      = page_q;
    head_d      = head_q;
    count_d     = count_q;
    k_d         = k_q;
    nk_d        = nk_q;
    idx_d       = idx_q;
    victim_d    = victim_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    used_d      = used_q;
    owner_d     = owner_q;
    fpage_d     = fpage_q;
    active_d    = active_q;
    pages_d     = pages_q;
    pm_we       = 1'b0;
    pm_waddr    = {slot_q, page_q};
    pm_wdata    = '0;
    pm_raddr    = {slot_q, page_q};
    ff_we       = 1'b0;
    ff_waddr    = head_q + count_q[FRAME_W-1:0];
    ff_wdata    = '0;
    ff_raddr    = head_q;
    vic         = '0;
    tf          = ff_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          slot_d = process_slot_i;
          page_d = page_number_i;
          res_d  = '0;
          idx_d  = '0;
          k_d    = '0;
          nk_d   = '0;
          state_d = S_DONE;
          unique case (func_i)
            FN_CREATE: begin
              if (active_q[process_slot_i] || page_count_i == '0) begin
                res_d.status = ST_REFUSED;
              end else begin
                active_d[process_slot_i] = 1'b1;
                pages_d[process_slot_i] = (page_count_i > PCNT_W'(MAX_PAGES)) ?
                                          PCNT_W'(MAX_PAGES) : page_count_i;
                res_d.status = ST_CREATED;
                state_d = S_CLR;
              end
            end
            FN_ACCESS: begin
              if (!active_q[process_slot_i]) begin
                res_d.status = ST_INACTIVE;
              end else if (PCNT_W'(page_number_i) >= pages_q[process_slot_i]) begin
                res_d.status = ST_RANGE;
              end else begin
                state_d = S_LOOK;
              end
            end
            FN_TERM: begin
              if (!active_q[process_slot_i]) begin
                res_d.status = ST_INACTIVE;
              end else begin
                res_d.status = ST_TERM;
                state_d = S_TRD;
              end
            end
            default: begin
              res_d.status = ST_REFUSED;
            end
          endcase
        end
      end
      S_CLR: begin
        pm_we    = 1'b1;
        pm_waddr = {slot_q, idx_q};
        idx_d    = idx_q + 1'b1;
        if (idx_q == PAGE_W'(MAX_PAGES - 1)) begin
          if (func_q == FN_TERM) begin
            active_d[slot_q] = 1'b0;
            pages_d[slot_q]  = '0;
          end
          state_d = S_DONE;
        end
      end
      S_LOOK: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (pm_rdata[MAP_W-1]) begin
          res_d.status = ST_HIT;
          res_d.frame  = pm_rdata[FRAME_W-1:0];
          state_d = S_DONE;
        end else begin
          if (count_q < cap) begin
            vic = free_idx;
            res_d.status = ST_FREE;
            count_d = count_q + 1'b1;
          end else begin
            vic = ff_rdata;
            head_d = head_q + 1'b1;
            res_d.status = ST_REPLACED;
            if (used_q[vic]) begin
              pm_we    = 1'b1;
              pm_waddr = {owner_q[vic], fpage_q[vic]};
              res_d.ev_valid = 1'b1;
              res_d.ev_slot  = owner_q[vic];
              res_d.ev_page  = fpage_q[vic];
            end
          end
          used_d[vic]  = 1'b1;
          owner_d[vic] = slot_q;
          fpage_d[vic] = page_q;
          ff_we    = 1'b1;
          ff_wdata = vic;
          res_d.frame = vic;
          victim_d = vic;
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        pm_we    = 1'b1;
        pm_wdata = {1'b1, victim_q};
        state_d  = S_DONE;
      end
      S_TRD: begin
        ff_raddr = head_q + k_q[FRAME_W-1:0];
        if (k_q == count_q) begin
          count_d = nk_q;
          idx_d   = '0;
          state_d = S_TFREE;
        end else begin
          state_d = S_TCHK;
        end
      end
      S_TCHK: begin
        if (!(used_q[tf] && owner_q[tf] == slot_q)) begin
          ff_we    = 1'b1;
          ff_waddr = head_q + nk_q[FRAME_W-1:0];
          ff_wdata = tf;
          nk_d     = nk_q + 1'b1;
        end
        k_d = k_q + 1'b1;
        state_d = S_TRD;
      end
      S_TFREE: begin
        if (used_q[idx_q[FRAME_W-1:0]] && owner_q[idx_q[FRAME_W-1:0]] == slot_q) begin
          used_d[idx_q[FRAME_W-1:0]]  = 1'b0;
          owner_d[idx_q[FRAME_W-1:0]] = '0;
          fpage_d[idx_q[FRAME_W-1:0]] = '0;
          res_d.freed = res_q.freed + 1'b1;
        end
        if (idx_q == PAGE_W'(NUM_FRAMES - 1)) begin
          idx_d   = '0;
          state_d = S_CLR;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= 5'(NUM_FRAMES);
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      active_q    <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        owner_q[i] <= '0;
        fpage_q[i] <= '0;
      end
      for (int i = 0; i < MAX_PROCS; i++) begin
        pages_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      active_q    <= active_d;
      owner_q     <= owner_d;
      fpage_q     <= fpage_d;
      pages_q     <= pages_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    slot_q   <= slot_d;
    page_q   <= page_d;
    k_q      <= k_d;
    nk_q     <= nk_d;
    idx_q    <= idx_d;
    victim_q <= victim_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign frame_o         = out_q.frame;
  assign evicted_valid_o = out_q.ev_valid;
  assign evicted_slot_o  = out_q.ev_slot;
  assign evicted_page_o  = out_q.ev_page;
  assign freed_count_o   = out_q.freed;

endmodule

// ===== rtl/core/fpfa_checker.sv =====
// Port-level checks for the FIFO page-frame allocator, bound to the top level.
// Depends on fpfa_pkg and fifo_page_frame_allocator.
module fpfa_checker
  import fpfa_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] func_i,
  input logic [1:0] process_slot_i,
  input logic [5:0] page_number_i,
  input logic [6:0] page_count_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [3:0] frame_o,
  input logic       evicted_valid_o,
  input logic [1:0] evicted_slot_o,
  input logic [5:0] evicted_page_o,
  input logic [4:0] freed_count_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [4:0] cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(frame_o))
    else $error("result transfer dropped or changed while stalled");

  a_evict_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_valid_o |-> status_o == ST_REPLACED)
    else $error("eviction reported without replacement");

  a_freed_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && freed_count_o != '0 |-> status_o == ST_TERM)
    else $error("freed frames reported outside terminate");

  a_err_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_RANGE || status_o == ST_INACTIVE ||
                    status_o == ST_REFUSED) |-> frame_o == '0 && !evicted_valid_o)
    else $error("error result carries a frame");

endmodule

bind fifo_page_frame_allocator fpfa_checker u_fpfa_checker (.*);

// ===== test/tb.sv =====
// Testbench for fifo_page_frame_allocator: random and directed page requests,
// results checked against an in-bench allocator model in a scoreboard class.
// Depends on fpfa_pkg and the block's RTL.
module tb;
  import fpfa_pkg::*;

  class alloc_scoreboard;
    res_t             expected_q[$];
    int               errors;
    logic [4:0]       frames_reg;
    logic             frame_used[NUM_FRAMES];
    logic [1:0]       frame_owner[NUM_FRAMES];
    logic [5:0]       frame_page[NUM_FRAMES];
    logic             map_valid[MAX_PROCS][MAX_PAGES];
    logic [3:0]       map_frame[MAX_PROCS][MAX_PAGES];
    logic             slot_active[MAX_PROCS];
    logic [6:0]       slot_pages[MAX_PROCS];
    logic [3:0]       ring[NUM_FRAMES];
    logic [3:0]       ring_head;
    int               ring_count;

    function new();
      errors = 0;
      frames_reg = 5'd16;
      ring_head = '0;
      ring_count = 0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_used[i] = 1'b0;
        frame_owner[i] = '0;
        frame_page[i] = '0;
      end
      for (int s = 0; s < MAX_PROCS; s++) begin
        slot_active[s] = 1'b0;
        slot_pages[s] = '0;
        for (int p = 0; p < MAX_PAGES; p++) map_valid[s][p] = 1'b0;
      end
    endfunction

    function int capacity();
      if (frames_reg < 1) return 1;
      if (frames_reg > NUM_FRAMES) return NUM_FRAMES;
      return frames_reg;
    endfunction

    function void clear_map(int s);
      for (int p = 0; p < MAX_PAGES; p++) map_valid[s][p] = 1'b0;
    endfunction

    function void note_request(logic [1:0] fn, logic [1:0] s, logic [5:0] pg,
                               logic [6:0] cnt);
      res_t r;
      int   victim;
      int   kept[$];
      r = '0;
      r.status = ST_REFUSED;
      if (fn == FN_CREATE) begin
        if (!slot_active[s] && cnt != 0) begin
          slot_active[s] = 1'b1;
          slot_pages[s] = (cnt > MAX_PAGES) ? 7'(MAX_PAGES) : cnt;
          clear_map(s);
          r.status = ST_CREATED;
        end
      end else if (fn == FN_ACCESS) begin
        if (!slot_active[s]) r.status = ST_INACTIVE;
        else if (pg >= slot_pages[s]) r.status = ST_RANGE;
        else if (map_valid[s][pg]) begin
          r.status = ST_HIT;
          r.frame = map_frame[s][pg];
        end else begin
          victim = 0;
          if (ring_count < capacity()) begin
            for (int i = capacity() - 1; i >= 0; i--)
              if (!frame_used[i]) victim = i;
            r.status = ST_FREE;
          end else begin
            victim = ring[ring_head];
            ring_head = ring_head + 1;
            ring_count--;
            if (frame_used[victim]) begin
              map_valid[frame_owner[victim]][frame_page[victim]] = 1'b0;
              r.ev_valid = 1'b1;
              r.ev_slot = frame_owner[victim];
              r.ev_page = frame_page[victim];
            end
            r.status = ST_REPLACED;
          end
          frame_used[victim] = 1'b1;
          frame_owner[victim] = s;
          frame_page[victim] = pg;
          map_valid[s][pg] = 1'b1;
          map_frame[s][pg] = 4'(victim);
          ring[4'(ring_head + ring_count)] = 4'(victim);
          ring_count++;
          r.frame = 4'(victim);
        end
      end else if (fn == FN_TERM) begin
        if (!slot_active[s]) r.status = ST_INACTIVE;
        else begin
          for (int k = 0; k < ring_count; k++) begin
            victim = ring[4'(ring_head + k)];
            if (!(frame_used[victim] && frame_owner[victim] == s)) kept.push_back(victim);
          end
          foreach (kept[k]) ring[4'(ring_head + k)] = 4'(kept[k]);
          ring_count = kept.size();
          for (int i = 0; i < NUM_FRAMES; i++) begin
            if (frame_used[i] && frame_owner[i] == s) begin
              frame_used[i] = 1'b0;
              frame_owner[i] = '0;
              frame_page[i] = '0;
              r.freed++;
            end
          end
          clear_map(s);
          slot_active[s] = 1'b0;
          slot_pages[s] = '0;
          r.status = ST_TERM;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) report($sformatf("status %0d exp %0d", got.status, e.status));
      if (got.frame !== e.frame) report($sformatf("frame %0d exp %0d", got.frame, e.frame));
      if (got.ev_valid !== e.ev_valid)
        report($sformatf("evicted_valid %0d exp %0d", got.ev_valid, e.ev_valid));
      if (got.ev_slot !== e.ev_slot)
        report($sformatf("evicted_slot %0d exp %0d", got.ev_slot, e.ev_slot));
      if (got.ev_page !== e.ev_page)
        report($sformatf("evicted_page %0d exp %0d", got.ev_page, e.ev_page));
      if (got.freed !== e.freed) report($sformatf("freed_count %0d exp %0d", got.freed, e.freed));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] func_i = '0;
  logic [1:0] process_slot_i = '0;
  logic [5:0] page_number_i = '0;
  logic [6:0] page_count_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [3:0] frame_o;
  logic       evicted_valid_o;
  logic [1:0] evicted_slot_o;
  logic [5:0] evicted_page_o;
  logic [4:0] freed_count_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i = '0;

  alloc_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 150;

  always #5 clk_i = ~clk_i;

  fifo_page_frame_allocator dut (.*);

  task automatic send_request(logic [1:0] fn, logic [1:0] s, logic [5:0] pg,
                              logic [6:0] cnt);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i <= fn;
    process_slot_i <= s;
    page_number_i <= pg;
    page_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(fn, s, pg, cnt);
  endtask

  task automatic set_frames(logic [4:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.frames_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_request();
    int          r;
    logic [1:0]  s;
    logic [6:0]  cnt;
    r = $urandom_range(0, 99);
    s = 2'($urandom_range(0, 3));
    if (r < 72) begin
      if (!sb.slot_active[s] && $urandom_range(0, 3) != 0)
        for (int i = 0; i < MAX_PROCS; i++) if (sb.slot_active[i]) s = 2'(i);
      if (sb.slot_active[s] && $urandom_range(0, 9) != 0)
        send_request(FN_ACCESS, s, 6'($urandom_range(0, sb.slot_pages[s] - 1)), 7'($urandom));
      else
        send_request(FN_ACCESS, s, 6'($urandom), 7'($urandom));
    end else if (r < 84) begin
      case ($urandom_range(0, 9))
        0: cnt = 7'd0;
        1: cnt = 7'($urandom_range(65, 127));
        default: cnt = 7'($urandom_range(1, 64));
      endcase
      send_request(FN_CREATE, s, 6'($urandom), cnt);
    end else if (r < 92) begin
      send_request(FN_TERM, s, 6'($urandom), 7'($urandom));
    end else begin
      send_request(2'd3, s, 6'($urandom), 7'($urandom));
    end
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{status_o, frame_o, evicted_valid_o, evicted_slot_o,
                        evicted_page_o, freed_count_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [4:0] phase_frames[7];
    phase_frames = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd3, 5'd16};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_frames(5'd4);
    send_request(FN_ACCESS, 2'd0, 6'd0, 7'd0);
    send_request(FN_TERM, 2'd1, 6'd0, 7'd0);
    send_request(FN_CREATE, 2'd0, 6'd0, 7'd0);
    send_request(FN_CREATE, 2'd0, 6'd63, 7'd127);
    send_request(FN_CREATE, 2'd0, 6'd0, 7'd5);
    send_request(FN_CREATE, 2'd3, 6'd0, 7'd64);
    send_request(FN_CREATE, 2'd1, 6'd0, 7'd1);
    send_request(2'd3, 2'd2, 6'd63, 7'd127);
    send_request(FN_ACCESS, 2'd0, 6'd63, 7'd0);
    send_request(FN_ACCESS, 2'd3, 6'd63, 7'd0);
    send_request(FN_ACCESS, 2'd0, 6'd0, 7'd0);
    send_request(FN_ACCESS, 2'd0, 6'd63, 7'd0);
    send_request(FN_ACCESS, 2'd1, 6'd0, 7'd0);
    send_request(FN_ACCESS, 2'd3, 6'd1, 7'd0);
    send_request(FN_ACCESS, 2'd3, 6'd2, 7'd0);
    send_request(FN_ACCESS, 2'd1, 6'd1, 7'd0);
    send_request(FN_ACCESS, 2'd3, 6'd63, 7'd0);
    send_request(FN_TERM, 2'd3, 6'd0, 7'd0);
    send_request(FN_ACCESS, 2'd0, 6'd0, 7'd0);
    send_request(FN_ACCESS, 2'd3, 6'd5, 7'd0);
    send_request(FN_TERM, 2'd0, 6'd0, 7'd0);
    send_request(FN_TERM, 2'd1, 6'd0, 7'd0);

    foreach (phase_frames[ph]) begin
      set_frames(phase_frames[ph]);
      if (ph == 6) no_idle = 1'b1;
      for (int n = 0; n < 150; n++) begin
        if (ph == 0 && n == 40) hold_req = 1'b1;
        random_request();
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
